FILE: rtl/core/fpa_pkg.sv
package fpa_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = 2 * WORD_BITS;

    localparam logic [3:0] MODE_ADD      = 4'd0;
    localparam logic [3:0] MODE_SUB      = 4'd1;
    localparam logic [3:0] MODE_MUL      = 4'd2;
    localparam logic [3:0] MODE_DIV      = 4'd3;
    localparam logic [3:0] MODE_GT       = 4'd4;
    localparam logic [3:0] MODE_LT       = 4'd5;
    localparam logic [3:0] MODE_GE       = 4'd6;
    localparam logic [3:0] MODE_LE       = 4'd7;
    localparam logic [3:0] MODE_EQ       = 4'd8;
    localparam logic [3:0] MODE_NE       = 4'd9;
    localparam logic [3:0] MODE_INC      = 4'd10;
    localparam logic [3:0] MODE_DEC      = 4'd11;
    localparam logic [3:0] MODE_MIN      = 4'd12;
    localparam logic [3:0] MODE_MAX      = 4'd13;
    localparam logic [3:0] MODE_FROM_INT = 4'd14;
    localparam logic [3:0] MODE_TO_INT   = 4'd15;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DIVZ = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [3:0]                  mode;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } t_cmd;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_value;
        logic                        compare_true;
        logic [1:0]                  status;
    } t_result;

    // Pack a sign and magnitude into a word, saturating to the nearest bound.
    function automatic t_result sat_pack(input logic neg, input logic [MAG_BITS-1:0] mag);
        logic [MAG_BITS-1:0] lim;
        t_result r;
        lim = MAG_BITS'(1) << (WORD_BITS - 1);
        r.compare_true = 1'b0;
        r.status       = STATUS_OK;
        if (!neg && mag >= lim) begin
            r.result_value = WORD_MAX;
            r.status       = STATUS_SAT;
        end else if (neg && mag > lim) begin
            r.result_value = WORD_MIN;
            r.status       = STATUS_SAT;
        end else if (neg) begin
            r.result_value = -$signed(mag[WORD_BITS-1:0]);
        end else begin
            r.result_value = $signed(mag[WORD_BITS-1:0]);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/fpa_delay.sv
module fpa_delay import fpa_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [0:DEPTH-1];

    // Advance the line one stage per clock.
    always_ff @(posedge i_clk) begin
        r_line[0] <= i_data;
        for (int k = 1; k < DEPTH; k++) begin
            r_line[k] <= r_line[k-1];
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

FILE: rtl/core/fpa_simple.sv
module fpa_simple import fpa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic    i_clk,
    input  t_cmd    i_cmd,
    output t_result o_result
);

    logic signed [WORD_BITS:0]   sa;
    logic signed [WORD_BITS:0]   sy;
    logic signed [WORD_BITS:0]   ssum;
    logic [FRACTION_BITS:0]      top_bits;
    logic                        lt;
    logic                        gt;
    logic                        eq;
    t_result                     n_result;
    t_result                     r_result;

    always_comb begin
        sa = {i_cmd.operand_a[WORD_BITS-1], i_cmd.operand_a};
        case (i_cmd.mode)
            MODE_SUB: sy = -{i_cmd.operand_b[WORD_BITS-1], i_cmd.operand_b};
            MODE_INC: sy = (WORD_BITS+1)'(1);
            MODE_DEC: sy = -(WORD_BITS+1)'(1);
            default:  sy = {i_cmd.operand_b[WORD_BITS-1], i_cmd.operand_b};
        endcase
        ssum     = sa + sy;
        top_bits = i_cmd.operand_a[WORD_BITS-1 -: FRACTION_BITS+1];
        lt = i_cmd.operand_a < i_cmd.operand_b;
        gt = i_cmd.operand_a > i_cmd.operand_b;
        eq = i_cmd.operand_a == i_cmd.operand_b;

        n_result.result_value = '0;
        n_result.compare_true = 1'b0;
        n_result.status       = STATUS_OK;
        case (i_cmd.mode)
            MODE_GT: n_result.compare_true = gt;
            MODE_LT: n_result.compare_true = lt;
            MODE_GE: n_result.compare_true = !lt;
            MODE_LE: n_result.compare_true = !gt;
            MODE_EQ: n_result.compare_true = eq;
            MODE_NE: n_result.compare_true = !eq;
            MODE_MIN: n_result.result_value = lt ? i_cmd.operand_a : i_cmd.operand_b;
            MODE_MAX: n_result.result_value = gt ? i_cmd.operand_a : i_cmd.operand_b;
            MODE_FROM_INT: begin
                if (top_bits == '0 || top_bits == '1) begin
                    n_result.result_value = i_cmd.operand_a <<< FRACTION_BITS;
                end else begin
                    n_result.result_value = i_cmd.operand_a[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
                    n_result.status       = STATUS_SAT;
                end
            end
            MODE_TO_INT: n_result.result_value = i_cmd.operand_a >>> FRACTION_BITS;
            default: begin
                // add, sub, inc, dec: one extra bit shows overflow
                if (ssum[WORD_BITS] != ssum[WORD_BITS-1]) begin
                    n_result.result_value = ssum[WORD_BITS] ? WORD_MIN : WORD_MAX;
                    n_result.status       = STATUS_SAT;
                end else begin
                    n_result.result_value = ssum[WORD_BITS-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

FILE: rtl/core/fpa_mul.sv
module fpa_mul import fpa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic    i_clk,
    input  t_cmd    i_cmd,
    output t_result o_result
);

    localparam logic [MAG_BITS:0] HALF = (MAG_BITS+1)'(1) << (FRACTION_BITS - 1);

    logic [WORD_BITS-1:0] r_am;
    logic [WORD_BITS-1:0] r_bm;
    logic                 r_neg0;
    logic [MAG_BITS-1:0]  r_prod;
    logic                 r_neg1;
    logic [MAG_BITS:0]    rounded;
    t_result              r_result;

    // Stage 1: magnitudes and sign.
    always_ff @(posedge i_clk) begin
        r_am   <= i_cmd.operand_a[WORD_BITS-1] ? WORD_BITS'(-i_cmd.operand_a)
                                               : WORD_BITS'(i_cmd.operand_a);
        r_bm   <= i_cmd.operand_b[WORD_BITS-1] ? WORD_BITS'(-i_cmd.operand_b)
                                               : WORD_BITS'(i_cmd.operand_b);
        r_neg0 <= i_cmd.operand_a[WORD_BITS-1] ^ i_cmd.operand_b[WORD_BITS-1];
    end

    // Stage 2: full product.
    always_ff @(posedge i_clk) begin
        r_prod <= MAG_BITS'(r_am) * MAG_BITS'(r_bm);
        r_neg1 <= r_neg0;
    end

    // Stage 3: round half away from zero on the magnitude, then saturate.
    assign rounded = ({1'b0, r_prod} + HALF) >> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        r_result <= sat_pack(r_neg1, rounded[MAG_BITS-1:0]);
    end

    assign o_result = r_result;

endmodule

FILE: rtl/core/fpa_div.sv
module fpa_div import fpa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic    i_clk,
    input  t_cmd    i_cmd,
    output t_result o_result
);

    localparam int NUM_BITS = WORD_BITS + FRACTION_BITS;

    logic [NUM_BITS-1:0]  r_num  [0:NUM_BITS];
    logic [WORD_BITS-1:0] r_den  [0:NUM_BITS];
    logic [WORD_BITS-1:0] r_rem  [0:NUM_BITS];
    logic [NUM_BITS-1:0]  r_quo  [0:NUM_BITS];
    logic                 r_neg  [0:NUM_BITS];
    logic                 r_zero [0:NUM_BITS];

    logic [WORD_BITS-1:0] a_mag;
    logic [NUM_BITS:0]    r_qr;
    logic                 r_qneg;
    logic                 r_qzero;
    logic [NUM_BITS:0]    n_qr;
    t_result              n_result;
    t_result              r_result;

    assign a_mag = i_cmd.operand_a[WORD_BITS-1] ? WORD_BITS'(-i_cmd.operand_a)
                                                : WORD_BITS'(i_cmd.operand_a);

    // Load: scaled numerator, divisor magnitude, sign.
    always_ff @(posedge i_clk) begin
        r_num[0]  <= {a_mag, {FRACTION_BITS{1'b0}}};
        r_den[0]  <= i_cmd.operand_b[WORD_BITS-1] ? WORD_BITS'(-i_cmd.operand_b)
                                                  : WORD_BITS'(i_cmd.operand_b);
        r_rem[0]  <= '0;
        r_quo[0]  <= '0;
        r_neg[0]  <= i_cmd.operand_a[WORD_BITS-1] ^ i_cmd.operand_b[WORD_BITS-1];
        r_zero[0] <= i_cmd.operand_b == '0;
    end

    // One restoring step per stage, most significant numerator bit first.
    for (genvar k = 0; k < NUM_BITS; k++) begin : g_step
        logic [WORD_BITS-1:0] trial;
        logic                 fits;

        assign trial = {r_rem[k][WORD_BITS-2:0], r_num[k][NUM_BITS-1-k]};
        assign fits  = trial >= r_den[k];

        always_ff @(posedge i_clk) begin
            r_num[k+1]  <= r_num[k];
            r_den[k+1]  <= r_den[k];
            r_rem[k+1]  <= fits ? trial - r_den[k] : trial;
            r_quo[k+1]  <= {r_quo[k][NUM_BITS-2:0], fits};
            r_neg[k+1]  <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    // Round up when the remainder is at least half the divisor.
    assign n_qr = {1'b0, r_quo[NUM_BITS]}
                + (NUM_BITS+1)'({r_rem[NUM_BITS], 1'b0} >= {1'b0, r_den[NUM_BITS]});

    always_ff @(posedge i_clk) begin
        r_qr    <= n_qr;
        r_qneg  <= r_neg[NUM_BITS];
        r_qzero <= r_zero[NUM_BITS];
    end

    always_comb begin
        n_result = sat_pack(r_qneg, MAG_BITS'(r_qr));
        if (r_qzero) begin
            n_result.result_value = '0;
            n_result.status       = STATUS_DIVZ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

FILE: rtl/core/fixed_point_q24_8_alu.sv
// Signed Q24.8 fixed-point ALU (fraction width set by FRACTION_BITS). Issue a
// command by raising start with the mode and operands on i_cmd; busy is never
// raised, so a new command may be issued every cycle. Each command yields one
// result on o_result, marked by a one-cycle o_done strobe (the default
// FRACTION_BITS of 8 gives Q24.8); results leave in issue order and must be
// taken in the cycle they appear. The divider is the longest unit: one
// restoring step per pipeline stage over the 32 + FRACTION_BITS bits of the
// scaled numerator, plus load, round and saturate stages. All other modes are
// delayed to match the divider.
// Multiply and divide round to nearest with ties away from zero; overflow
// saturates with status 2, division by zero returns 0 with status 1.
module fixed_point_q24_8_alu_core import fpa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    // Divider latency measured from the command register.
    localparam int DIV_LAT = WORD_BITS + FRACTION_BITS + 3;
    localparam int MUL_LAT = 3;
    localparam int SMP_LAT = 1;

    logic               r_valid;
    t_cmd               r_cmd;
    logic [DIV_LAT-1:0] r_vld_line;
    logic               r_done;
    t_result            r_result;
    t_result            n_result;

    t_result            smp_res;
    t_result            mul_res;
    t_result            div_res;
    t_result            smp_dly;
    t_result            mul_dly;
    logic [3:0]         mode_dly;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Capture the command on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= i_cmd;
    end

    fpa_simple #(.FRACTION_BITS(FRACTION_BITS)) u_simple (
        .i_clk    (i_clk),
        .i_cmd    (r_cmd),
        .o_result (smp_res)
    );

    fpa_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_cmd    (r_cmd),
        .o_result (mul_res)
    );

    fpa_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk    (i_clk),
        .i_cmd    (r_cmd),
        .o_result (div_res)
    );

    // Align the short units with the divider.
    fpa_delay #(.WIDTH($bits(t_result)), .DEPTH(DIV_LAT - SMP_LAT)) u_smp_dly (
        .i_clk  (i_clk),
        .i_data (smp_res),
        .o_data (smp_dly)
    );

    fpa_delay #(.WIDTH($bits(t_result)), .DEPTH(DIV_LAT - MUL_LAT)) u_mul_dly (
        .i_clk  (i_clk),
        .i_data (mul_res),
        .o_data (mul_dly)
    );

    fpa_delay #(.WIDTH(4), .DEPTH(DIV_LAT)) u_mode_dly (
        .i_clk  (i_clk),
        .i_data (r_cmd.mode),
        .o_data (mode_dly)
    );

    // Valid bits travel beside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_line <= '0;
        end else begin
            r_vld_line <= {r_vld_line[DIV_LAT-2:0], r_valid};
        end
    end

    // Pick the unit that owns the mode.
    always_comb begin
        unique case (mode_dly)
            MODE_MUL: n_result = mul_dly;
            MODE_DIV: n_result = div_res;
            default:  n_result = smp_dly;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld_line[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
